// ----- hw/rtl/rmid_pkg.sv -----
// ----------------------------------------------------------------------------
// rmid_pkg
// Shared types and constants of the running median block.
// ----------------------------------------------------------------------------
package rmid_pkg;

    localparam int DEFAULT_CAPACITY = 64;
    localparam int VALUE_W  = 32;
    localparam int MEDIAN_W = 33;
    localparam int COUNT_W  = 7;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_ABSENT = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DELETE = 1'b1;

endpackage

// ----- hw/rtl/running_median_insert_delete_core.sv -----
// ----------------------------------------------------------------------------
// running_median_insert_delete_core
// Running median over a sorted multiset of signed Q16.16 samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (valid/ready): kind (0 insert, 1 delete one copy), value.
//   Output channel (valid/ready): median_doubled, element_count, status.
//   Every item gives exactly one result item.
//   The values are kept ascending in one single-port-per-side synchronous
//   memory (one write, one registered read per cycle). An item walks the
//   array once: a scan finds the position, then the tail is shifted up
//   (insert) or down (delete) one entry a cycle, with a registered
//   read-modify-write pipeline. The two middle entries are then read back.
//   Accept to result: the scan and the shift touch each entry once, then
//   the middle entries are read back; full insert and empty delete skip
//   the scan and the shift. The pace of items is set by the memory port
//   walking the array entry by entry.
//   Reset empties the store at once (count to zero); the memory is not
//   cleared, since only entries below the count are ever used.
//   A result waits in the output register while the receiver stalls; the
//   next item is accepted only after the result has been taken.
//   Full insert, absent delete and empty delete leave the store unchanged.
// ----------------------------------------------------------------------------
module running_median_insert_delete_core #(
    parameter int CAPACITY = rmid_pkg::DEFAULT_CAPACITY
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                kind,
    input  logic signed [rmid_pkg::VALUE_W-1:0] value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [rmid_pkg::MEDIAN_W-1:0] median_doubled,
    output logic [rmid_pkg::COUNT_W-1:0]        element_count,
    output logic [1:0]                          status
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef logic signed [rmid_pkg::VALUE_W-1:0] val_t;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_SCAN_W, S_INS, S_DEL, S_MID0, S_MID1, S_MID2, S_OUT
    } state_t;

    // memory
    val_t            mem [CAPACITY];
    logic [AW-1:0]   rd_addr;
    logic            rd_en;
    val_t            rd_data_reg;
    logic [AW-1:0]   wr_addr;
    logic            wr_en;
    val_t            wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    state_t          state_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   idx_reg;     // address issued in the previous cycle
    logic            kind_reg;
    val_t            val_reg;
    val_t            carry_reg;   // value to store at the next higher slot
    val_t            lo_reg;
    rmid_pkg::status_t st_reg;
    logic signed [rmid_pkg::MEDIAN_W-1:0] med_reg;
    logic            out_valid_reg;
    logic            hit;

    logic [CW-1:0]   mid;
    assign mid = count_reg >> 1;

    // combinational memory controls
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = carry_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            S_SCAN:
            begin
                // insert position found: new value goes to idx
                if (hit && kind_reg == rmid_pkg::KIND_INSERT)
                begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(idx_reg);
                    wr_data = val_reg;
                end
                rd_en   = 1'b1;
                rd_addr = AW'(idx_reg + CW'(1));
            end
            S_INS:
            begin
                // rd_data is old entry idx; write carry there, read next
                wr_en   = 1'b1;
                wr_addr = AW'(idx_reg);
                wr_data = carry_reg;
                rd_en   = 1'b1;
                rd_addr = AW'(idx_reg + CW'(1));
            end
            S_DEL:
            begin
                // rd_data is entry idx; store it at idx-1
                wr_en   = 1'b1;
                wr_addr = AW'(idx_reg - CW'(1));
                wr_data = rd_data_reg;
                rd_en   = 1'b1;
                rd_addr = AW'(idx_reg + CW'(1));
            end
            S_MID0:
            begin
                rd_en   = 1'b1;
                rd_addr = (mid == '0) ? '0 : AW'(mid - CW'(1));
            end
            S_MID1:
            begin
                rd_en   = 1'b1;
                rd_addr = AW'(mid);
            end
            default: ;
        endcase
    end

    always_comb
    begin
        if (kind_reg == rmid_pkg::KIND_INSERT)
            hit = rd_data_reg > val_reg;
        else
            hit = rd_data_reg == val_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        kind_reg <= kind;
                        val_reg  <= value;
                        idx_reg  <= '0;
                        carry_reg <= value;
                        if (kind == rmid_pkg::KIND_INSERT &&
                            count_reg >= CW'(CAPACITY))
                        begin
                            st_reg    <= rmid_pkg::ST_FULL;
                            state_reg <= S_MID0;
                        end
                        else if (kind == rmid_pkg::KIND_DELETE &&
                                 count_reg == '0)
                        begin
                            st_reg    <= rmid_pkg::ST_EMPTY;
                            state_reg <= S_MID0;
                        end
                        else
                        begin
                            st_reg <= rmid_pkg::ST_OK;
                            if (count_reg == '0)
                                state_reg <= S_SCAN_W; // insert into empty
                            else
                                state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    // rd_data_reg is entry idx
                    if (hit)
                    begin
                        if (kind_reg == rmid_pkg::KIND_INSERT)
                        begin
                            // old entry idx moves up one slot
                            carry_reg <= rd_data_reg;
                            idx_reg   <= idx_reg + CW'(1);
                            state_reg <= S_INS;
                        end
                        else if (idx_reg + CW'(1) >= count_reg)
                        begin
                            count_reg <= count_reg - CW'(1);
                            state_reg <= S_MID0;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + CW'(1);
                            state_reg <= S_DEL;
                        end
                    end
                    else if (idx_reg + CW'(1) >= count_reg)
                    begin
                        if (kind_reg == rmid_pkg::KIND_INSERT)
                        begin
                            idx_reg   <= idx_reg + CW'(1);
                            state_reg <= S_SCAN_W;
                        end
                        else
                        begin
                            st_reg    <= rmid_pkg::ST_ABSENT;
                            state_reg <= S_MID0;
                        end
                    end
                    else
                        idx_reg <= idx_reg + CW'(1);
                end
                S_SCAN_W:
                begin
                    // append at idx: single write done via S_INS last step
                    state_reg <= S_INS;
                end
                S_INS:
                begin
                    carry_reg <= rd_data_reg;
                    if (idx_reg >= count_reg)
                    begin
                        count_reg <= count_reg + CW'(1);
                        state_reg <= S_MID0;
                    end
                    else
                        idx_reg <= idx_reg + CW'(1);
                end
                S_DEL:
                begin
                    if (idx_reg + CW'(1) >= count_reg)
                    begin
                        count_reg <= count_reg - CW'(1);
                        state_reg <= S_MID0;
                    end
                    else
                        idx_reg <= idx_reg + CW'(1);
                end
                S_MID0:
                begin
                    state_reg <= S_MID1;
                end
                S_MID1:
                begin
                    lo_reg    <= rd_data_reg;
                    state_reg <= S_MID2;
                end
                S_MID2:
                begin
                    if (count_reg == '0)
                        med_reg <= '0;
                    else if (count_reg[0])
                        med_reg <= {rd_data_reg, 1'b0};
                    else
                        med_reg <= {lo_reg[rmid_pkg::VALUE_W-1], lo_reg} +
                                   {rd_data_reg[rmid_pkg::VALUE_W-1], rd_data_reg};
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign median_doubled = med_reg;
    assign element_count  = rmid_pkg::COUNT_W'(count_reg);
    assign status         = st_reg;

endmodule

// ----- hw/rtl/rmid_checker.sv -----
// ----------------------------------------------------------------------------
// rmid_checker
// Port-level checks of the running median block, bound to the top level.
// ----------------------------------------------------------------------------
module rmid_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] element_count,
    input logic [1:0] status
);
    // one item in flight: no accept while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("accept while result pending");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(element_count))
        else $error("result dropped");

    a_status_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(status))
        else $error("status changed while stalled");

    a_accept_rule: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready) else $error("double accept");

endmodule

bind running_median_insert_delete_core rmid_checker u_rmid_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .element_count(element_count), .status(status)
);

// ----- verif/running_median_insert_delete_core_tb.sv -----
// ----------------------------------------------------------------------------
// running_median_insert_delete_core_tb
// Drives insert and delete items into the running median core, predicts
// the doubled median, count and status of each item from a sorted model
// store, and compares every result item against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module running_median_insert_delete_core_tb;

    localparam int CAP = rmid_pkg::DEFAULT_CAPACITY;

    typedef struct packed {
        logic                                 kind;
        logic signed [rmid_pkg::VALUE_W-1:0]  value;
    } sample_item_t;

    typedef struct packed {
        logic signed [rmid_pkg::MEDIAN_W-1:0] median;
        logic [rmid_pkg::COUNT_W-1:0]         count;
        rmid_pkg::status_t                    st;
    } median_result_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic kind;
    logic signed [rmid_pkg::VALUE_W-1:0] value;
    logic out_valid;
    logic out_ready;
    logic signed [rmid_pkg::MEDIAN_W-1:0] median_doubled;
    logic [rmid_pkg::COUNT_W-1:0] element_count;
    logic [1:0] status;

    running_median_insert_delete_core #(.CAPACITY(CAP)) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .value          (value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .median_doubled (median_doubled),
        .element_count  (element_count),
        .status         (status)
    );

    // model of the sorted store
    logic signed [rmid_pkg::VALUE_W-1:0] sorted_store [CAP];
    int held;

    sample_item_t   pending_items [$];
    median_result_t expected_medians [$];
    int  mismatches;
    bit  idle_enable;
    bit  hold_for_drain;

    always #2 clk = ~clk;

    // Predict one item: update the model store, return the result item.
    function automatic median_result_t predict_median(sample_item_t it);
        median_result_t r;
        int pos;
        r.st = rmid_pkg::ST_OK;
        if (it.kind == rmid_pkg::KIND_INSERT) begin
            if (held >= CAP) begin
                r.st = rmid_pkg::ST_FULL;
            end else begin
                pos = 0;
                while (pos < held && sorted_store[pos] <= it.value) pos++;
                for (int k = held; k > pos; k--) sorted_store[k] = sorted_store[k-1];
                sorted_store[pos] = it.value;
                held++;
            end
        end else if (held == 0) begin
            r.st = rmid_pkg::ST_EMPTY;
        end else begin
            pos = 0;
            while (pos < held && sorted_store[pos] != it.value) pos++;
            if (pos >= held) begin
                r.st = rmid_pkg::ST_ABSENT;
            end else begin
                for (int k = pos; k + 1 < held; k++) sorted_store[k] = sorted_store[k+1];
                held--;
            end
        end
        if (held == 0)
            r.median = '0;
        else if (held % 2)
            r.median = rmid_pkg::MEDIAN_W'(sorted_store[held/2]) <<< 1;
        else
            r.median = rmid_pkg::MEDIAN_W'(sorted_store[held/2-1]) +
                       rmid_pkg::MEDIAN_W'(sorted_store[held/2]);
        r.count = rmid_pkg::COUNT_W'(held);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Input accept seen at the rising edge, used by the driver at the falling one.
    logic in_taken;
    always @(posedge clk) begin
        in_taken <= rst_n && in_valid && in_ready;
    end

    // Driver: present one item at a time; inputs change on falling edges.
    int in_gap;
    always @(negedge clk) begin
        if (rst_n) begin
            if (in_taken) begin
                expected_medians.push_back(predict_median(pending_items.pop_front()));
                if (idle_enable && $urandom_range(0, 5) == 0)
                    in_gap = $urandom_range(1, 17);
            end
            if (in_valid && !in_taken) begin
                // hold item stable until accepted
            end else if (in_gap > 0) begin
                in_gap--;
                in_valid <= 1'b0;
            end else if (hold_for_drain && expected_medians.size() != 0) begin
                in_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                in_valid <= 1'b1;
                kind     <= pending_items[0].kind;
                value    <= pending_items[0].value;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure in bursts.
    int out_gap;
    always @(negedge clk) begin
        if (rst_n) begin
            if (out_gap > 0) begin
                out_gap--;
                out_ready <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 4) == 0) begin
                out_gap = $urandom_range(0, 16);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Monitor: check each accepted result item against the oldest prediction.
    median_result_t want;
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_medians.size() == 0) begin
                report_mismatch("unexpected result, count", element_count, -1);
            end else begin
                want = expected_medians.pop_front();
                if (median_doubled !== want.median)
                    report_mismatch("median_doubled", median_doubled, want.median);
                if (element_count !== want.count)
                    report_mismatch("element_count", element_count, want.count);
                if (status !== want.st)
                    report_mismatch("status", status, want.st);
            end
        end
    end

    function automatic sample_item_t mk(logic k, logic signed [rmid_pkg::VALUE_W-1:0] v);
        sample_item_t it;
        it.kind  = k;
        it.value = v;
        return it;
    endfunction

    // Random value: mostly from a small pool so deletes hit, some extremes.
    function automatic logic signed [rmid_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed(32'($urandom_range(0, 40)) - 32'd20) <<< 16;
        endcase
    endfunction

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = rmid_pkg::KIND_INSERT;
        value = '0;
        out_ready = 1'b0;
        in_gap = 0;
        out_gap = 0;
        held = 0;
        mismatches = 0;
        idle_enable = 1'b1;
        hold_for_drain = 1'b0;
        for (int i = 0; i < CAP; i++) sorted_store[i] = '0;

        // Directed: empty delete, extremes, duplicates, absent delete.
        pending_items.push_back(mk(rmid_pkg::KIND_DELETE, 32'sd5));
        pending_items.push_back(mk(rmid_pkg::KIND_INSERT, 32'sh7fffffff));
        pending_items.push_back(mk(rmid_pkg::KIND_INSERT, 32'sh7fffffff));
        pending_items.push_back(mk(rmid_pkg::KIND_INSERT, 32'sh80000000));
        pending_items.push_back(mk(rmid_pkg::KIND_INSERT, 32'sh80000000));
        pending_items.push_back(mk(rmid_pkg::KIND_INSERT, 32'sh00010000));
        pending_items.push_back(mk(rmid_pkg::KIND_DELETE, 32'sh12345678));
        pending_items.push_back(mk(rmid_pkg::KIND_DELETE, 32'sh7fffffff));
        pending_items.push_back(mk(rmid_pkg::KIND_DELETE, 32'sh80000000));
        pending_items.push_back(mk(rmid_pkg::KIND_DELETE, 32'sh00010000));
        pending_items.push_back(mk(rmid_pkg::KIND_DELETE, 32'sh80000000));
        pending_items.push_back(mk(rmid_pkg::KIND_DELETE, 32'sh7fffffff));
        pending_items.push_back(mk(rmid_pkg::KIND_DELETE, 32'shffffffff));
        pending_items.push_back(mk(rmid_pkg::KIND_INSERT, 32'shffffffff));
        pending_items.push_back(mk(rmid_pkg::KIND_INSERT, 32'sh00000000));
        pending_items.push_back(mk(rmid_pkg::KIND_DELETE, 32'shffffffff));
        pending_items.push_back(mk(rmid_pkg::KIND_DELETE, 32'sh00000000));

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Fill to full and beyond, then drain past empty.
        for (int i = 0; i < CAP + 3; i++)
            pending_items.push_back(mk(rmid_pkg::KIND_INSERT, pick_value()));
        wait (pending_items.size() == 0 && expected_medians.size() == 0);

        // From here, each item waits until every earlier result has arrived.
        hold_for_drain = 1'b1;
        for (int i = 0; i < CAP + 3; i++)
            pending_items.push_back(mk(rmid_pkg::KIND_DELETE,
                                       sorted_store[(i < CAP) ? i : 0]));
        for (int i = 0; i < 380; i++)
            pending_items.push_back(mk($urandom_range(0, 2) == 0, pick_value()));
        wait (pending_items.size() < 300);
        hold_for_drain = 1'b0;
        wait (pending_items.size() < 60);
        idle_enable = 1'b0;
        wait (pending_items.size() == 0 && expected_medians.size() == 0);
        repeat (2 * CAP + 20) @(posedge clk);

        if (mismatches == 0 && expected_medians.size() == 0)
            $display("running_median_insert_delete_core: match");
        else
            $display("running_median_insert_delete_core: mismatch");
        $finish;
    end

    initial begin
        #4000000;
        $display("running_median_insert_delete_core: mismatch");
        $finish;
    end

endmodule
